FILE: rtl/core/fndc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N divider calculator package
// Widths, register indexes, divider codes and the stage records that travel
// down the two division cell chains.
// ----------------------------------------------------------------------------
package fndc_pkg;

    localparam int TARGET_W  = 30;
    localparam int CRYSTAL_W = 26;
    localparam int RDIV_W    = 4;
    localparam int FRAC_BITS = 12;
    localparam int FRAC_W    = 12;
    localparam int INT_W     = 16;
    localparam int CODE_W    = 2;
    localparam int WORD_W    = 23;
    localparam int NBYTE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int QUO_W     = TARGET_W + FRAC_BITS;
    localparam int N_W       = QUO_W - FRAC_BITS;

    localparam int S_TDATA_W = ((TARGET_W + 7) / 8) * 8;
    localparam int M_FIELD_W = INT_W + FRAC_W + CODE_W + WORD_W + 1;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CRYSTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_DIV   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER = 2'd2;

    localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET = 26'd16000000;
    localparam logic [RDIV_W-1:0]    REF_DIV_RESET = 4'd1;

    // Output divider codes and their frequency thresholds.
    localparam logic [CODE_W-1:0] DIV_BY1 = 2'd0;
    localparam logic [CODE_W-1:0] DIV_BY2 = 2'd1;
    localparam logic [CODE_W-1:0] DIV_BY4 = 2'd2;
    localparam logic [CODE_W-1:0] DIV_BY8 = 2'd3;

    localparam logic [TARGET_W-1:0] THRESH_DIV1 = 30'd410000000;
    localparam logic [TARGET_W-1:0] THRESH_DIV2 = 30'd210000000;
    localparam logic [TARGET_W-1:0] THRESH_DIV4 = 30'd130000000;

    localparam logic [1:0] WORD_ADDR = 2'b01;

    // Crystal / R chain: quotient bits shift in at the bottom of dq.
    typedef struct packed {
        logic                  valid;
        logic [CODE_W-1:0]     code;
        logic [TARGET_W-1:0]   target;
        logic [RDIV_W-1:0]     rem;
        logic [CRYSTAL_W-1:0]  dq;
    } pfd_stage_t;

    // (target << FRAC_BITS) / f_pfd chain.
    typedef struct packed {
        logic                  valid;
        logic [CODE_W-1:0]     code;
        logic [CRYSTAL_W-1:0]  divisor;
        logic [CRYSTAL_W-1:0]  rem;
        logic [QUO_W-1:0]      dq;
    } quo_stage_t;

endpackage

FILE: rtl/core/fractional_n_divider_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N divider calculator
// Turns a target frequency into integer N, a 12-bit fraction, the output
// divider code and the packed synthesizer N register word.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry target_hz. Each beat gives exactly one output
//   beat on m_*, in order. Configuration (crystal_hz, ref_divider,
//   prescaler_sel) is written through cfg_we/cfg_index/cfg_data while no
//   beat is in flight; unknown indexes are ignored.
//   The work is two chains of one-bit restoring-division cells: 26 cells
//   form f_pfd = crystal_hz / R, then 42 cells divide target_hz << 12 by it.
//   A beat passes through every cell register, then the output register;
//   one beat per cycle is accepted and delivered in steady state while the receiver does not stall.
//   Reset clears all valid flags and loads the register reset values
//   (16 MHz crystal, R = 1, prescaler 4/5).
//   When the receiver stalls, the result in flight lands in a skid register
//   and the cell chains freeze in the following cycle; s_tready drops only while
//   that skid register is full.
// ----------------------------------------------------------------------------
module fractional_n_divider_calc
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [29:0] target_hz
    input  logic [fndc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] integer_part, [27:16] fraction_part, [29:28] out_div_code,
    // [52:30] n_register_word, [53] n_overflow
    output logic [fndc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_we,
    input  logic [fndc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fndc_pkg::CRYSTAL_W-1:0]    cfg_data
);

    logic [fndc_pkg::CRYSTAL_W-1:0] crystal_reg;
    logic [fndc_pkg::RDIV_W-1:0]    ref_div_reg;
    logic                           prescaler_reg;
    logic [fndc_pkg::RDIV_W-1:0]    r_eff;

    logic                           en;
    logic [fndc_pkg::TARGET_W-1:0]  target;
    logic [fndc_pkg::CODE_W-1:0]    code;

    fndc_pkg::pfd_stage_t           pfd_chain [0:fndc_pkg::CRYSTAL_W];
    fndc_pkg::quo_stage_t           quo_chain [0:fndc_pkg::QUO_W];
    fndc_pkg::quo_stage_t           last;

    logic [fndc_pkg::N_W-1:0]       n_full;
    logic                           pfd_zero;
    logic [fndc_pkg::INT_W-1:0]     int_part;
    logic [fndc_pkg::FRAC_W-1:0]    frac_part;
    logic [fndc_pkg::NBYTE_W-1:0]   n_byte;
    logic                           n_ovf;
    logic [fndc_pkg::WORD_W-1:0]    word;
    logic [fndc_pkg::M_TDATA_W-1:0] fmt;

    logic                           out_free;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [fndc_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [fndc_pkg::M_TDATA_W-1:0] out_data_next;
    logic                           skid_valid_reg;
    logic                           skid_valid_next;
    logic [fndc_pkg::M_TDATA_W-1:0] skid_data_reg;
    logic [fndc_pkg::M_TDATA_W-1:0] skid_data_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crystal_reg   <= fndc_pkg::CRYSTAL_RESET;
            ref_div_reg   <= fndc_pkg::REF_DIV_RESET;
            prescaler_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fndc_pkg::CFG_CRYSTAL:   crystal_reg   <= cfg_data;
                fndc_pkg::CFG_REF_DIV:   ref_div_reg   <= cfg_data[fndc_pkg::RDIV_W-1:0];
                fndc_pkg::CFG_PRESCALER: prescaler_reg <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // A zero reference divider behaves as divide by one.
    assign r_eff = (ref_div_reg == '0) ? fndc_pkg::RDIV_W'(1) : ref_div_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign target   = s_tdata[fndc_pkg::TARGET_W-1:0];

    always_comb
    begin
        priority if (target < fndc_pkg::THRESH_DIV4)
            code = fndc_pkg::DIV_BY8;
        else if (target < fndc_pkg::THRESH_DIV2)
            code = fndc_pkg::DIV_BY4;
        else if (target < fndc_pkg::THRESH_DIV1)
            code = fndc_pkg::DIV_BY2;
        else
            code = fndc_pkg::DIV_BY1;
    end

    always_comb
    begin
        pfd_chain[0].valid  = s_tvalid;
        pfd_chain[0].code   = code;
        pfd_chain[0].target = target;
        pfd_chain[0].rem    = '0;
        pfd_chain[0].dq     = crystal_reg;
    end

    for (genvar i = 0; i < fndc_pkg::CRYSTAL_W; i++)
    begin : g_pfd
        fndc_pfd_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (r_eff),
            .in_stage  (pfd_chain[i]),
            .out_stage (pfd_chain[i+1])
        );
    end

    // The fraction bits come from extending the dividend with zeros.
    always_comb
    begin
        quo_chain[0].valid   = pfd_chain[fndc_pkg::CRYSTAL_W].valid;
        quo_chain[0].code    = pfd_chain[fndc_pkg::CRYSTAL_W].code;
        quo_chain[0].divisor = pfd_chain[fndc_pkg::CRYSTAL_W].dq;
        quo_chain[0].rem     = '0;
        quo_chain[0].dq      = {pfd_chain[fndc_pkg::CRYSTAL_W].target,
                                {fndc_pkg::FRAC_BITS{1'b0}}};
    end

    for (genvar j = 0; j < fndc_pkg::QUO_W; j++)
    begin : g_quo
        fndc_quo_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_stage  (quo_chain[j]),
            .out_stage (quo_chain[j+1])
        );
    end

    assign last = quo_chain[fndc_pkg::QUO_W];

    // Result formatting. A zero phase-detector frequency reads as N all ones.
    always_comb
    begin
        n_full   = last.dq[fndc_pkg::QUO_W-1:fndc_pkg::FRAC_BITS];
        pfd_zero = (last.divisor == '0);
        if (pfd_zero)
        begin
            int_part  = '1;
            frac_part = '0;
            n_byte    = '1;
            n_ovf     = 1'b1;
        end
        else
        begin
            int_part  = (n_full > fndc_pkg::N_W'(16'hFFFF)) ? '1
                                                            : n_full[fndc_pkg::INT_W-1:0];
            frac_part = fndc_pkg::FRAC_W'(last.dq[fndc_pkg::FRAC_BITS-1:0]);
            n_byte    = n_full[fndc_pkg::NBYTE_W-1:0];
            n_ovf     = (n_full > fndc_pkg::N_W'(8'hFF));
        end
        word = {prescaler_reg, n_byte, frac_part, fndc_pkg::WORD_ADDR};
        fmt  = fndc_pkg::M_TDATA_W'({n_ovf, word, last.code, frac_part, int_part});
    end

    // Output register with a skid register behind it.
    always_comb
    begin
        out_free        = !out_valid_reg || m_tready;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (last.valid)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fmt;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = fmt;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: rtl/core/fndc_pfd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference divide cell
// One restoring-division step of crystal_hz / R, registered.
// ----------------------------------------------------------------------------
module fndc_pfd_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [fndc_pkg::RDIV_W-1:0] divisor,
    input  fndc_pkg::pfd_stage_t        in_stage,
    output fndc_pkg::pfd_stage_t        out_stage
);

    logic [fndc_pkg::RDIV_W:0]  trial;
    logic [fndc_pkg::RDIV_W:0]  diff;
    logic                       fits;
    fndc_pkg::pfd_stage_t       stage_next;
    fndc_pkg::pfd_stage_t       stage_reg;
    logic                       valid_reg;

    always_comb
    begin
        trial      = {in_stage.rem, in_stage.dq[fndc_pkg::CRYSTAL_W-1]};
        diff       = trial - {1'b0, divisor};
        fits       = (trial >= {1'b0, divisor});
        stage_next = in_stage;
        stage_next.rem = fits ? diff[fndc_pkg::RDIV_W-1:0] : trial[fndc_pkg::RDIV_W-1:0];
        stage_next.dq  = {in_stage.dq[fndc_pkg::CRYSTAL_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        out_stage       = stage_reg;
        out_stage.valid = valid_reg;
    end

endmodule

FILE: rtl/core/fndc_quo_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frequency divide cell
// One restoring-division step of (target << FRAC_BITS) / f_pfd, registered.
// ----------------------------------------------------------------------------
module fndc_quo_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  fndc_pkg::quo_stage_t in_stage,
    output fndc_pkg::quo_stage_t out_stage
);

    logic [fndc_pkg::CRYSTAL_W:0] trial;
    logic [fndc_pkg::CRYSTAL_W:0] diff;
    logic                         fits;
    fndc_pkg::quo_stage_t         stage_next;
    fndc_pkg::quo_stage_t         stage_reg;
    logic                         valid_reg;

    always_comb
    begin
        trial      = {in_stage.rem, in_stage.dq[fndc_pkg::QUO_W-1]};
        diff       = trial - {1'b0, in_stage.divisor};
        fits       = (trial >= {1'b0, in_stage.divisor});
        stage_next = in_stage;
        stage_next.rem = fits ? diff[fndc_pkg::CRYSTAL_W-1:0]
                              : trial[fndc_pkg::CRYSTAL_W-1:0];
        stage_next.dq  = {in_stage.dq[fndc_pkg::QUO_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_stage.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        out_stage       = stage_reg;
        out_stage.valid = valid_reg;
    end

endmodule

FILE: rtl/core/fndc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractional-N divider calculator port checker
// Watches the top level's result ports and checks result beats for consistency.
// ----------------------------------------------------------------------------
module fndc_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fndc_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("fndc: result beat withdrawn under stall");

    // The word always carries the N register address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:30] == fndc_pkg::WORD_ADDR)
        else $error("fndc: register word address bits wrong");

    // The fraction in the word matches the fraction field.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[43:32] == m_tdata[27:16])
        else $error("fndc: word fraction differs from fraction field");

    // Without overflow, integer N fits the word's byte and matches it.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[53] |-> m_tdata[15:8] == 8'd0 && m_tdata[51:44] == m_tdata[7:0])
        else $error("fndc: overflow flag inconsistent with integer N");

endmodule

bind fractional_n_divider_calc fndc_checker u_fndc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/tb_fractional_n_divider_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the fractional-N divider calculator
// Streams target frequencies through the block under several crystal,
// reference divider and prescaler settings. Each output beat is checked
// field by field against an in-bench calculation of N, the fraction, the
// output divider code, the N register word and the overflow flag. Both
// stream sides idle at random, and one long output stall backs up the chain.
// ----------------------------------------------------------------------------
module tb_fractional_n_divider_calc;

    localparam logic [fndc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int TIMEOUT_CYCLES  = 300000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int MAX_REPORTS     = 100;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 100;
    localparam logic [63:0] TARGET_MASK = 64'h3FFF_FFFF;

    typedef struct packed {
        logic [fndc_pkg::INT_W-1:0]  n_int;
        logic [fndc_pkg::FRAC_W-1:0] frac;
        logic [fndc_pkg::CODE_W-1:0] code;
        logic [fndc_pkg::WORD_W-1:0] word;
        logic                        ovf;
    } tuning_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [fndc_pkg::S_TDATA_W-1:0]     s_tdata   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [fndc_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               cfg_we    = 1'b0;
    logic [fndc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [fndc_pkg::CRYSTAL_W-1:0]     cfg_data  = '0;

    // Register shadows used by the tuning calculation.
    logic [fndc_pkg::CRYSTAL_W-1:0]     cur_crystal   = fndc_pkg::CRYSTAL_RESET;
    logic [fndc_pkg::RDIV_W-1:0]        cur_ref_div   = fndc_pkg::REF_DIV_RESET;
    logic                               cur_prescaler = 1'b0;

    tuning_t pending_tunings[$];

    int  errors       = 0;
    int  reports      = 0;
    int  targets_sent = 0;
    int  tunings_seen = 0;
    int  settings_run = 1;
    int  cycle_count  = 0;
    int  stall_cycles = 0;
    bit  src_idle_en  = 1'b1;
    bit  rx_idle_en   = 1'b1;
    int  rx_hold_req  = 0;
    int  rx_left      = 0;

    fractional_n_divider_calc DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] current_pfd();
        logic [63:0] rdiv;
        rdiv = (cur_ref_div == '0) ? 64'd1 : {60'd0, cur_ref_div};
        return {38'd0, cur_crystal} / rdiv;
    endfunction

    function automatic tuning_t calc_tuning(input logic [fndc_pkg::TARGET_W-1:0] tgt);
        logic [63:0] pfd;
        logic [63:0] tgt64;
        logic [63:0] n;
        logic [63:0] rem;
        logic [63:0] frac;
        tuning_t     res;
        pfd   = current_pfd();
        tgt64 = {34'd0, tgt};
        if (pfd == '0)
        begin
            // A zero comparison frequency saturates N and zeroes the fraction.
            n    = 64'hFFFF_FFFF;
            frac = 64'd0;
        end
        else
        begin
            n    = tgt64 / pfd;
            rem  = tgt64 - n * pfd;
            frac = (rem << fndc_pkg::FRAC_BITS) / pfd;
        end
        res.n_int = (n > 64'hFFFF) ? 16'hFFFF : n[fndc_pkg::INT_W-1:0];
        res.frac  = frac[fndc_pkg::FRAC_W-1:0];
        if (tgt >= fndc_pkg::THRESH_DIV1)
            res.code = fndc_pkg::DIV_BY1;
        else if (tgt >= fndc_pkg::THRESH_DIV2)
            res.code = fndc_pkg::DIV_BY2;
        else if (tgt >= fndc_pkg::THRESH_DIV4)
            res.code = fndc_pkg::DIV_BY4;
        else
            res.code = fndc_pkg::DIV_BY8;
        res.word = {cur_prescaler, n[fndc_pkg::NBYTE_W-1:0], frac[fndc_pkg::FRAC_W-1:0],
                    fndc_pkg::WORD_ADDR};
        res.ovf  = (n > 64'hFF);
        return res;
    endfunction

    function automatic logic [fndc_pkg::TARGET_W-1:0] pick_target();
        logic [63:0] pfd;
        logic [63:0] val;
        pfd = current_pfd();
        case ($urandom_range(0, 9))
            4:
            begin
                case ($urandom_range(0, 2))
                    0:       val = {34'd0, fndc_pkg::THRESH_DIV1};
                    1:       val = {34'd0, fndc_pkg::THRESH_DIV2};
                    default: val = {34'd0, fndc_pkg::THRESH_DIV4};
                endcase
                val = val + 64'($urandom_range(0, 4)) - 64'd2;
            end
            5:
            begin
                // Land on, next to or between whole multiples of the comparison frequency.
                if (pfd == '0)
                    val = {32'd0, $urandom()};
                else
                begin
                    val = pfd * 64'($urandom_range(0, 1100));
                    case ($urandom_range(0, 3))
                        0:       val = val;
                        1:       val = val + 64'd1;
                        2:       val = val + pfd - 64'd1;
                        default: val = val + ({32'd0, $urandom()} % pfd);
                    endcase
                end
            end
            6:       val = 64'($urandom_range(0, 2000));
            7:       val = TARGET_MASK - 64'($urandom_range(0, 2000));
            default: val = {32'd0, $urandom()};
        endcase
        return val[fndc_pkg::TARGET_W-1:0];
    endfunction

    task automatic send_target(input logic [fndc_pkg::TARGET_W-1:0] tgt);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(fndc_pkg::S_TDATA_W - fndc_pkg::TARGET_W){1'b0}}, tgt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_tunings.push_back(calc_tuning(tgt));
        targets_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tunings.size() != 0);
    endtask

    task automatic program_reg(input logic [fndc_pkg::CFG_IDX_W-1:0] idx,
                               input logic [fndc_pkg::CRYSTAL_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            fndc_pkg::CFG_CRYSTAL:   cur_crystal   = data;
            fndc_pkg::CFG_REF_DIV:   cur_ref_div   = data[fndc_pkg::RDIV_W-1:0];
            fndc_pkg::CFG_PRESCALER: cur_prescaler = data[0];
            default:                 ;
        endcase
    endtask

    task automatic retune(input logic [fndc_pkg::CRYSTAL_W-1:0] xtal,
                          input logic [fndc_pkg::CRYSTAL_W-1:0] rdiv_data,
                          input logic [fndc_pkg::CRYSTAL_W-1:0] presc_data);
        wait_idle();
        program_reg(fndc_pkg::CFG_CRYSTAL, xtal);
        program_reg(fndc_pkg::CFG_REF_DIV, rdiv_data);
        program_reg(fndc_pkg::CFG_PRESCALER, presc_data);
        settings_run++;
    endtask

    task automatic test_reset_defaults();
        send_target(30'd0);
        send_target(30'd1);
        send_target(30'd15999999);
        send_target(30'd16000000);
        send_target(fndc_pkg::THRESH_DIV4 - 30'd1);
        send_target(fndc_pkg::THRESH_DIV4);
        send_target(fndc_pkg::THRESH_DIV2 - 30'd1);
        send_target(fndc_pkg::THRESH_DIV2);
        send_target(fndc_pkg::THRESH_DIV1 - 30'd1);
        send_target(fndc_pkg::THRESH_DIV1);
        send_target(30'h2AAA_AAAA);
        send_target(30'h1555_5555);
        send_target(30'h3FFF_FFFF);
    endtask

    task automatic test_register_corners();
        // A 1 MHz crystal: N runs past 255 and sets the overflow flag.
        retune(26'd1000000, 26'd1, 26'd1);
        send_target(30'h3FFF_FFFF);
        send_target(30'd255999999);
        send_target(30'd256000000);
        // Fastest crystal over the largest divider.
        retune(26'h3FF_FFFF, 26'd15, 26'd0);
        send_target(30'h3FFF_FFFF);
        send_target(30'd4473923);
        // A divider of zero acts as one; upper data bits must be dropped.
        retune(26'h3FF_FFFF, 26'h3FF_FFF0, 26'h3FF_FFFE);
        send_target(30'd536870904);
        send_target(30'd536870903);
        // Crystal below R gives a zero comparison frequency.
        retune(26'd14, 26'd15, 26'd1);
        send_target(30'd0);
        send_target(30'h3FFF_FFFF);
        retune(26'd0, 26'd1, 26'd0);
        send_target(30'd123456789);
        // A write to the spare index must leave every register alone.
        retune(26'd19200000, 26'd2, 26'd1);
        program_reg(CFG_SPARE, 26'h3FF_FFFF);
        send_target(30'd433920000);
    endtask

    task automatic test_random_settings();
        logic [fndc_pkg::CRYSTAL_W-1:0] xtal;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       xtal = 26'd1000000 + fndc_pkg::CRYSTAL_W'($urandom_range(0, 1000));
                1:       xtal = 26'h3FF_FFFF - fndc_pkg::CRYSTAL_W'($urandom_range(0, 1000));
                2:       xtal = fndc_pkg::CRYSTAL_W'($urandom_range(0, 20));
                default: xtal = fndc_pkg::CRYSTAL_W'($urandom_range(1000000, 67108863));
            endcase
            retune(xtal, fndc_pkg::CRYSTAL_W'($urandom()), fndc_pkg::CRYSTAL_W'($urandom()));
            if ($urandom_range(0, 2) == 0)
                program_reg(CFG_SPARE, fndc_pkg::CRYSTAL_W'($urandom()));
            // Alternate between both sides idling, neither, and each alone.
            src_idle_en = (phase % 4 == 0) || (phase % 4 == 2);
            rx_idle_en  = (phase % 4 == 0) || (phase % 4 == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_target(pick_target());
        end
        src_idle_en = 1'b1;
        rx_idle_en  = 1'b1;
    endtask

    task automatic test_output_backpressure();
        retune(26'd26000000, 26'd1, 26'd0);
        src_idle_en = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 400;
        for (int i = 0; i < 150; i++)
            send_target(pick_target());
        src_idle_en = 1'b1;
        rx_idle_en  = 1'b1;
    endtask

    // Receiver: a random pause after each beat while idling is enabled, plus one long hold on request.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            rx_left = rx_idle_en ? $urandom_range(0, 7) : 0;
        if (rx_hold_req != 0)
        begin
            rx_left     = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_left > 0)
        begin
            m_tready <= 1'b0;
            rx_left  = rx_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, exp_val, act_val);
            reports++;
        end
    endfunction

    always @(posedge clk)
    begin
        tuning_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            tunings_seen++;
            if (pending_tunings.size() == 0)
            begin
                errors++;
                $display("%0t: output beat with nothing expected, expected none actual %0h",
                         $time, m_tdata);
            end
            else
            begin
                want = pending_tunings.pop_front();
                check_field("integer_part",    32'(want.n_int), 32'(m_tdata[15:0]));
                check_field("fraction_part",   32'(want.frac),  32'(m_tdata[27:16]));
                check_field("out_div_code",    32'(want.code),  32'(m_tdata[29:28]));
                check_field("n_register_word", 32'(want.word),  32'(m_tdata[52:30]));
                check_field("n_overflow",      32'(want.ovf),   32'(m_tdata[53]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (s_tvalid && !s_tready)
            stall_cycles++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_tunings.size());
            $display("[fractional_n_divider_calc] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_corners();
        test_random_settings();
        test_output_backpressure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_tunings.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived, expected 0 actual %0d",
                     $time, pending_tunings.size(), pending_tunings.size());
        end
        $display("Checked %0d tuning requests against %0d results under %0d register settings.",
                 targets_sent, tunings_seen, settings_run);
        $display("Included zero-PFD, R of zero, N overflow, threshold edges; input stalled %0d cycles.",
                 stall_cycles);
        if (errors == 0)
            $display("[fractional_n_divider_calc] OK");
        else
            $display("[fractional_n_divider_calc] ERROR");
        $finish;
    end

endmodule
